FILE: rtl/core/iirl_pkg.sv
// shared types and codes for the indexed insert/remove list
// no dependencies; imported by every module of the block
package iirl_pkg;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SET    = 3'd3,
    ACT_REMOVE = 3'd4,
    ACT_CLEAR  = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic shift_up;    // insert: open a slot at lo, move lo..hi-1 up
    logic shift_down;  // remove: move lo+1..hi-1 down
    logic write;       // append or set: load the input word at lo
    logic read;        // return the word held at lo
  } cmd_t;

endpackage

FILE: rtl/core/iirl_cell.sv
// one list slot: holds a word and loads from the input, its left or its right neighbor
// depends on iirl_pkg
module iirl_cell #(
  parameter int INDEX         = 0,
  parameter int CW            = 5,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic                     clk,
  input  iirl_pkg::cmd_t           cmd,
  input  logic [CW-1:0]            lo,
  input  logic [CW-1:0]            hi,
  input  logic [ELEMENT_WIDTH-1:0] din,
  input  logic [ELEMENT_WIDTH-1:0] left,
  input  logic [ELEMENT_WIDTH-1:0] right,
  output logic [ELEMENT_WIDTH-1:0] word,
  output logic [ELEMENT_WIDTH-1:0] tap
);
  import iirl_pkg::*;

  localparam logic [CW-1:0] IDX    = CW'(INDEX);
  localparam logic [CW-1:0] IDX_P1 = CW'(INDEX + 1);

  logic [ELEMENT_WIDTH-1:0] word_next;

  // pick the source for this slot
  always_comb begin
    priority if (cmd.shift_up && IDX == lo) begin
      word_next = din;
    end else if (cmd.shift_up && IDX > lo && IDX <= hi) begin
      word_next = left;
    end else if (cmd.shift_down && IDX >= lo && IDX_P1 < hi) begin
      word_next = right;
    end else if (cmd.write && IDX == lo) begin
      word_next = din;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // read tap, or-gathered at the top
  assign tap = (IDX == lo) ? word : '0;

endmodule

FILE: rtl/core/iirl_ctrl.sv
// request decode, range and full checks, and the fill count register
// depends on iirl_pkg
module iirl_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CW       = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [2:0]          action,
  input  logic [4:0]          position,
  output iirl_pkg::cmd_t      cmd,
  output logic [CW-1:0]       lo,
  output logic [CW-1:0]       hi,
  output logic [CW-1:0]       count_next,
  output iirl_pkg::status_t   st
);
  import iirl_pkg::*;

  localparam int CMP_W = (CW > 5) ? CW : 5;

  logic [CW-1:0]    fill_count;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  cmd_t             dec;
  logic [CW-1:0]    cnt_upd;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(fill_count);
  assign full    = (fill_count == CW'(CAPACITY));
  assign hi      = fill_count;

  // decode one request against the current count
  always_comb begin
    dec     = '0;
    st      = ST_OK;
    cnt_upd = fill_count;
    lo      = pos_ext[CW-1:0];
    unique case (action_t'(action))
      ACT_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          dec.write = 1'b1;
          lo        = fill_count;
          cnt_upd   = fill_count + 1'b1;
        end
      end
      ACT_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          dec.shift_up = 1'b1;
          cnt_upd      = fill_count + 1'b1;
        end
      end
      ACT_GET: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          dec.read = 1'b1;
        end
      end
      ACT_SET: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          dec.read  = 1'b1;
          dec.write = 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          st = ST_RANGE;
        end else begin
          dec.read       = 1'b1;
          dec.shift_down = 1'b1;
          cnt_upd        = fill_count - 1'b1;
        end
      end
      ACT_CLEAR: begin
        cnt_upd = '0;
      end
      default: begin
      end
    endcase
  end

  // commands only act on an accepted beat
  assign cmd        = fire ? dec : '0;
  assign count_next = cnt_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (fire) begin
      fill_count <= cnt_upd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_err_hold: assert property (@(posedge clk) disable iff (rst)
    fire && st != ST_OK |=> fill_count == $past(fill_count))
    else $error("failed request changed the count");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.shift_up, cmd.shift_down, cmd.write}))
    else $error("more than one cell command at once");

  a_idle_stable: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(fill_count))
    else $error("count changed without a beat");

endmodule

FILE: rtl/core/indexed_insert_remove_list.sv
// Fixed-capacity ordered list held in a row of CAPACITY word cells. Each
// accepted beat is one request (append, insert, get, set, remove, clear) and
// yields exactly one result beat, registered at acceptance.
// Every request finishes at once: insert and remove move all
// affected cells at once along the row, so the block takes one request per
// cycle as long as the result register is drained. Positions and counts are
// checked against the fill count; out-of-range requests and appends or
// inserts into a full list change nothing and report an error status.
// Entries are not cleared at reset; only written entries are ever read.
// depends on iirl_pkg, iirl_ctrl, iirl_cell
module indexed_insert_remove_list #(
  parameter int CAPACITY      = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [4:0]  position,
  input  logic [31:0] element_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [4:0]  entry_count,
  output logic        is_empty,
  output logic [1:0]  status
);
  import iirl_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                     fire;
  cmd_t                     cmd;
  logic [CW-1:0]            lo;
  logic [CW-1:0]            hi;
  logic [CW-1:0]            count_next;
  status_t                  st;
  logic [ELEMENT_WIDTH-1:0] din;
  logic [ELEMENT_WIDTH-1:0] words [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] taps  [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] gather;

  // handshake: a new beat enters whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign din      = ELEMENT_WIDTH'(element_value);

  iirl_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .action     (action),
    .position   (position),
    .cmd        (cmd),
    .lo         (lo),
    .hi         (hi),
    .count_next (count_next),
    .st         (st)
  );

  // row of cells, each wired to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_w;
    logic [ELEMENT_WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    iirl_cell #(
      .INDEX         (i),
      .CW            (CW),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .lo    (lo),
      .hi    (hi),
      .din   (din),
      .left  (left_w),
      .right (right_w),
      .word  (words[i]),
      .tap   (taps[i])
    );
  end

  // or-gather of the addressed cell
  always_comb begin
    gather = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      gather = gather | taps[i];
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (fire) begin
      read_value  <= cmd.read ? 32'(gather) : '0;
      entry_count <= 5'(count_next);
      is_empty    <= (count_next == '0);
      status      <= st;
    end
  end

endmodule

FILE: sim/testbench.sv
// self-checking bench for the indexed insert/remove list
// depends on iirl_pkg and the indexed_insert_remove_list rtl
`timescale 1ns / 1ps

module testbench;
  import iirl_pkg::*;

  localparam int LIST_DEPTH     = 16;
  localparam int PHASE_ITEMS    = 450;
  localparam int HOLD_AT_RESULT = 1100;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 200000;

  // action codes the package leaves undefined; the list must ignore them
  localparam logic [2:0] UNUSED_ACT_6 = 3'd6;
  localparam logic [2:0] UNUSED_ACT_7 = 3'd7;

  typedef struct packed {
    logic [31:0] read_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    status_t     status;
  } list_result_t;

  typedef struct packed {
    logic [2:0]   act;
    logic [4:0]   pos;
    logic [31:0]  val;
    logic [4:0]   reps;
    logic         fixed_want;
    list_result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = ACT_APPEND;
  logic [4:0]  position = '0;
  logic [31:0] element_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_value;
  logic [4:0]  entry_count;
  logic        is_empty;
  logic [1:0]  status;

  // shadow copy of the list
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len = 0;

  list_result_t pending_results [$];
  int           mismatch_count = 0;
  int           results_seen = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           cycle_count = 0;

  indexed_insert_remove_list #(
    .CAPACITY      (LIST_DEPTH),
    .ELEMENT_WIDTH (32)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .position      (position),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .read_value    (read_value),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .status        (status)
  );

  always #10 clk = ~clk;

  // apply one request to the shadow list and return the result it must give
  function automatic list_result_t apply_list_request(logic [2:0] act, logic [4:0] pos,
                                                      logic [31:0] val);
    list_result_t res;
    res = '{32'd0, 5'd0, 1'b0, ST_OK};
    case (act)
      ACT_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      ACT_INSERT: begin
        if (int'(pos) > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_len; i > int'(pos); i--) list_words[i] = list_words[i-1];
          list_words[int'(pos)] = val;
          list_len++;
        end
      end
      ACT_GET: begin
        if (int'(pos) >= list_len) res.status = ST_RANGE;
        else res.read_value = list_words[int'(pos)];
      end
      ACT_SET: begin
        if (int'(pos) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[int'(pos)];
          list_words[int'(pos)] = val;
        end
      end
      ACT_REMOVE: begin
        if (int'(pos) >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_words[int'(pos)];
          for (int i = int'(pos); i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ACT_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.entry_count = list_len[4:0];
    res.is_empty    = (list_len == 0);
    return res;
  endfunction

  // offer one request beat, wait for it to be taken, then log what it must return
  task automatic send_request(logic [2:0] act, logic [4:0] pos, logic [31:0] val,
                              logic fixed_want, list_result_t want);
    list_result_t predicted;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    position      <= pos;
    element_value <= val;
    do @(posedge clk); while (!in_ready);
    predicted = apply_list_request(act, pos, val);
    pending_results.push_back(fixed_want ? want : predicted);
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** indexed_insert_remove_list: FAILED **");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off, field checks
  initial begin
    int           hold_left;
    list_result_t want;
    hold_left = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            mismatch_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            mismatch_count++;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
          end
        end
        results_seen++;
        if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // request side: directed table, then three random phases
  initial begin
    directed_row_t directed_rows [$];
    list_result_t  no_want;
    logic [2:0]    act;
    logic [4:0]    pos;
    logic [31:0]   val;
    int            pick;
    bit            growing;

    no_want = '{32'd0, 5'd0, 1'b0, ST_OK};
    directed_rows = '{
      // empty list: every indexed access is out of range
      '{ACT_GET,      5'd0,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_RANGE}},
      '{ACT_REMOVE,   5'd3,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_RANGE}},
      '{ACT_SET,      5'd0,  32'h1,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_RANGE}},
      '{ACT_INSERT,   5'd1,  32'h2,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_RANGE}},
      '{ACT_CLEAR,    5'd0,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_OK}},
      // insert at the end acts as append; word extremes
      '{ACT_INSERT,   5'd0,  32'hFFFFFFFF, 5'd1,  1'b1, '{32'd0, 5'd1,  1'b0, ST_OK}},
      '{ACT_APPEND,   5'd0,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd2,  1'b0, ST_OK}},
      '{ACT_INSERT,   5'd1,  32'hA5A5A5A5, 5'd1,  1'b0, no_want},
      '{ACT_GET,      5'd2,  32'h0,        5'd1,  1'b0, no_want},
      '{ACT_SET,      5'd0,  32'h5A5A5A5A, 5'd1,  1'b0, no_want},
      '{ACT_REMOVE,   5'd1,  32'h0,        5'd1,  1'b0, no_want},
      '{UNUSED_ACT_6, 5'd5,  32'h12345678, 5'd1,  1'b0, no_want},
      '{UNUSED_ACT_7, 5'd16, 32'hFFFFFFFF, 5'd1,  1'b0, no_want},
      // fill to capacity, then hit the full and range checks
      '{ACT_APPEND,   5'd0,  32'h80000000, 5'd14, 1'b0, no_want},
      '{ACT_APPEND,   5'd0,  32'hDEADBEEF, 5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, ST_FULL}},
      '{ACT_INSERT,   5'd16, 32'h0,        5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, ST_FULL}},
      '{ACT_INSERT,   5'd0,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, ST_FULL}},
      '{ACT_GET,      5'd16, 32'h0,        5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, ST_RANGE}},
      '{ACT_REMOVE,   5'd16, 32'h0,        5'd1,  1'b1, '{32'd0, 5'd16, 1'b0, ST_RANGE}},
      '{ACT_GET,      5'd15, 32'h0,        5'd1,  1'b0, no_want},
      '{ACT_REMOVE,   5'd0,  32'h0,        5'd1,  1'b0, no_want},
      '{ACT_INSERT,   5'd15, 32'h0F0F0F0F, 5'd1,  1'b0, no_want},
      '{ACT_REMOVE,   5'd15, 32'h0,        5'd1,  1'b0, no_want},
      '{ACT_SET,      5'd7,  32'hFFFF0000, 5'd1,  1'b0, no_want},
      '{ACT_CLEAR,    5'd9,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_OK}},
      '{ACT_GET,      5'd0,  32'h0,        5'd1,  1'b1, '{32'd0, 5'd0,  1'b1, ST_RANGE}}
    };
    growing = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      for (int r = 0; r < int'(directed_rows[k].reps); r++) begin
        send_request(directed_rows[k].act, directed_rows[k].pos,
                     directed_rows[k].val + 32'(r), directed_rows[k].fixed_want,
                     directed_rows[k].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 56 : 0;
      recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 17 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sweep the fill level up and down so full and empty both recur
        pick = $urandom_range(99);
        if (growing) begin
          if (pick < 28) act = ACT_APPEND;
          else if (pick < 56) act = ACT_INSERT;
          else if (pick < 70) act = ACT_GET;
          else if (pick < 84) act = ACT_SET;
          else if (pick < 99) act = ACT_REMOVE;
          else act = ACT_CLEAR;
        end else begin
          if (pick < 10) act = ACT_APPEND;
          else if (pick < 20) act = ACT_INSERT;
          else if (pick < 35) act = ACT_GET;
          else if (pick < 50) act = ACT_SET;
          else if (pick < 99) act = ACT_REMOVE;
          else act = ACT_CLEAR;
        end

        // mostly in-range positions, some anywhere in 0..16
        if ($urandom_range(99) < 12) begin
          pos = 5'($urandom_range(16));
        end else begin
          case (act)
            ACT_INSERT: pos = 5'($urandom_range(list_len));
            ACT_GET, ACT_SET, ACT_REMOVE:
              pos = (list_len > 0) ? 5'($urandom_range(list_len - 1))
                                   : 5'($urandom_range(16));
            default: pos = 5'($urandom_range(16));
          endcase
        end

        pick = $urandom_range(7);
        val = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;

        send_request(act, pos, val, 1'b0, no_want);

        if (list_len == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
        else if (list_len == 0) growing = 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** indexed_insert_remove_list: PASSED **");
    end else begin
      $display("** indexed_insert_remove_list: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/iirl_pkg.sv
rtl/core/iirl_cell.sv
rtl/core/iirl_ctrl.sv
rtl/core/indexed_insert_remove_list.sv
sim/testbench.sv
